// ===== design/jtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_pkg - shared types and constants of the JSON token lexer
// Beat types, token kinds, lexer modes, character codes and the small
// keyword tables used by the front end.
// ----------------------------------------------------------------------------
package jtl_pkg;

    // Offset counter width: capped at 16 bits because the token fields are 16.
    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = (OFFSET_BITS > 16) ? 16 : OFFSET_BITS;
    localparam logic [OFF_W-1:0] OFF_TOP = '1;

    // Token queue between front and back (depth must be a power of two).
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [QPTR_W:0] QCNT_ONE  = {{QPTR_W{1'b0}}, 1'b1};
    localparam logic [QPTR_W:0] QCNT_FULL = (QPTR_W + 1)'(QDEPTH);

    // Character codes.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;

    typedef enum logic [3:0] {
        KIND_LBRACE = 4'd0,
        KIND_RBRACE = 4'd1,
        KIND_COLON  = 4'd2,
        KIND_COMMA  = 4'd3,
        KIND_LBRACK = 4'd4,
        KIND_RBRACK = 4'd5,
        KIND_STRING = 4'd6,
        KIND_NUMBER = 4'd7,
        KIND_BOOL   = 4'd8,
        KIND_NULL   = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_WORD = 2'd3
    } t_mode;

    // Keyword candidate bits.
    localparam int KW_TRUE  = 0;
    localparam int KW_FALSE = 1;
    localparam int KW_NULL  = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_marker;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        bool_value;
        logic        last_of_run;
        logic        offset_overflow;
    } t_out_beat;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        bool_value;
    } t_token;

    // One queue entry holds every token that a single input byte produces.
    typedef struct packed {
        t_token tok_a;
        logic   a_valid;
        t_token tok_b;
        logic   b_valid;
        logic   overflow;
    } t_entry;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_num_char(input logic [7:0] b);
        return is_digit(b) || (b == CH_DOT) || (b == CH_MINUS) ||
               (b == CH_LOW_E) || (b == CH_UP_E);
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        return (k == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // Character idx of keyword k; zero beyond the keyword's end.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (k == KW_TRUE) begin
            unique case (idx)
                3'd0: c = 8'h74;
                3'd1: c = 8'h72;
                3'd2: c = 8'h75;
                3'd3: c = 8'h65;
                default: c = 8'h00;
            endcase
        end else if (k == KW_FALSE) begin
            unique case (idx)
                3'd0: c = 8'h66;
                3'd1: c = 8'h61;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h73;
                3'd4: c = 8'h65;
                default: c = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0: c = 8'h6E;
                3'd1: c = 8'h75;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h6C;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Drop every keyword that cannot match once letter b lands at position wlen.
    function automatic logic [2:0] word_step(input logic [2:0] cand, input logic [2:0] wlen,
                                             input logic [7:0] b);
        logic [2:0] r;
        r = cand;
        for (int k = 0; k < 3; k++) begin
            if ((wlen >= kw_len(k)) || (kw_char(k, wlen) != b)) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/jtl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_front - byte classifier and lexer state
// Accepts one text beat per cycle while the queue has room, updates the lexer
// mode and offsets, pushes one entry of up to two tokens if the byte yields any.
// ----------------------------------------------------------------------------
module jtl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  jtl_pkg::t_in_beat i_data,
    input  logic             i_room,
    output logic             o_push,
    output jtl_pkg::t_entry  o_entry
);
    import jtl_pkg::*;

    t_mode             r_mode, n_mode;
    logic [OFF_W-1:0]  r_offset, n_offset;
    logic [OFF_W-1:0]  r_begin, n_begin;
    logic [2:0]        r_cand, n_cand;
    logic [2:0]        r_wlen, n_wlen;
    logic              r_ovf, n_ovf;

    logic              accept;
    logic [7:0]        b;
    logic [15:0]       cur_len;
    logic              do_idle;
    t_token            tok_a, tok_b;
    logic              a_valid, b_valid;
    t_token            word_tok;
    logic              word_hit;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign b       = i_data.byte_value;
    assign cur_len = 16'(r_offset) - 16'(r_begin);

    // Closing a word: first surviving keyword whose length matches.
    always_comb begin
        word_tok            = '0;
        word_tok.kind       = KIND_BOOL;
        word_tok.start      = 16'(r_begin);
        word_tok.length     = {13'd0, r_wlen};
        word_hit            = 1'b0;
        priority if (r_cand[KW_TRUE] && (r_wlen == kw_len(KW_TRUE))) begin
            word_hit            = 1'b1;
            word_tok.bool_value = 1'b1;
        end else if (r_cand[KW_FALSE] && (r_wlen == kw_len(KW_FALSE))) begin
            word_hit = 1'b1;
        end else if (r_cand[KW_NULL] && (r_wlen == kw_len(KW_NULL))) begin
            word_hit      = 1'b1;
            word_tok.kind = KIND_NULL;
        end else begin
            word_hit = 1'b0;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_offset = r_offset;
        n_begin  = r_begin;
        n_cand   = r_cand;
        n_wlen   = r_wlen;
        n_ovf    = r_ovf;
        tok_a    = '0;
        tok_b    = '0;
        a_valid  = 1'b0;
        b_valid  = 1'b0;
        do_idle  = 1'b0;

        tok_a.start  = 16'(r_begin);
        tok_a.length = cur_len;
        tok_b.start  = 16'(r_offset);

        if (i_data.end_marker) begin
            unique case (r_mode)
                MODE_STR: begin
                    a_valid    = 1'b1;
                    tok_a.kind = KIND_STRING;
                end
                MODE_NUM: begin
                    a_valid    = 1'b1;
                    tok_a.kind = KIND_NUMBER;
                end
                MODE_WORD: begin
                    a_valid = word_hit;
                    tok_a   = word_tok;
                end
                MODE_IDLE: a_valid = 1'b0;
            endcase
            n_mode   = MODE_IDLE;
            n_offset = '0;
            n_begin  = '0;
            n_cand   = 3'b111;
            n_wlen   = 3'd0;
            n_ovf    = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        a_valid    = 1'b1;
                        tok_a.kind = KIND_STRING;
                        n_mode     = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (!is_num_char(b)) begin
                        a_valid    = 1'b1;
                        tok_a.kind = KIND_NUMBER;
                        n_mode     = MODE_IDLE;
                        do_idle    = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_letter(b)) begin
                        n_cand = word_step(r_cand, r_wlen, b);
                        n_wlen = (r_wlen == 3'd7) ? r_wlen : r_wlen + 3'd1;
                    end else begin
                        a_valid = word_hit;
                        tok_a   = word_tok;
                        n_mode  = MODE_IDLE;
                        do_idle = 1'b1;
                    end
                end
                MODE_IDLE: do_idle = 1'b1;
            endcase

            if (do_idle) begin
                priority if (b == CH_LBRACE) begin
                    b_valid = 1'b1; tok_b.kind = KIND_LBRACE;
                end else if (b == CH_RBRACE) begin
                    b_valid = 1'b1; tok_b.kind = KIND_RBRACE;
                end else if (b == CH_COLON) begin
                    b_valid = 1'b1; tok_b.kind = KIND_COLON;
                end else if (b == CH_COMMA) begin
                    b_valid = 1'b1; tok_b.kind = KIND_COMMA;
                end else if (b == CH_LBRACK) begin
                    b_valid = 1'b1; tok_b.kind = KIND_LBRACK;
                end else if (b == CH_RBRACK) begin
                    b_valid = 1'b1; tok_b.kind = KIND_RBRACK;
                end else if (b == CH_QUOTE) begin
                    n_mode  = MODE_STR;
                    n_begin = (r_offset < OFF_TOP) ? r_offset + 1'b1 : OFF_TOP;
                end else if (is_digit(b) || (b == CH_MINUS)) begin
                    n_mode  = MODE_NUM;
                    n_begin = r_offset;
                end else if (is_letter(b)) begin
                    n_mode  = MODE_WORD;
                    n_begin = r_offset;
                    n_cand  = word_step(3'b111, 3'd0, b);
                    n_wlen  = 3'd1;
                end else begin
                    b_valid = 1'b0;
                end
            end

            if (r_offset < OFF_TOP) begin
                n_offset = r_offset + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_offset <= '0;
            r_begin  <= '0;
            r_cand   <= 3'b111;
            r_wlen   <= 3'd0;
            r_ovf    <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_begin  <= n_begin;
            r_cand   <= n_cand;
            r_wlen   <= n_wlen;
            r_ovf    <= n_ovf;
        end
    end

    assign o_push           = accept && (a_valid || b_valid);
    assign o_entry.tok_a    = tok_a;
    assign o_entry.a_valid  = a_valid;
    assign o_entry.tok_b    = tok_b;
    assign o_entry.b_valid  = b_valid;
    assign o_entry.overflow = r_ovf;

endmodule

// ===== design/jtl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_queue - token entry queue
// Small register queue that decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
module jtl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jtl_pkg::t_entry i_entry,
    output logic            o_room,
    input  logic            i_pop,
    output logic            o_head_valid,
    output jtl_pkg::t_entry o_head
);
    import jtl_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_room       = (r_count != QCNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_ONE;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_ONE;
            end
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_room) |-> i_pop)
        else $error("queue pushed while full");

    a_head_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_valid |-> (o_head.a_valid || o_head.b_valid))
        else $error("queue entry without any token");
`endif

endmodule

// ===== design/jtl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtl_back - token serializer and output register
// Sends the one or two tokens of the head entry as separate result beats.
// ----------------------------------------------------------------------------
module jtl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  jtl_pkg::t_entry    i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output jtl_pkg::t_out_beat o_data
);
    import jtl_pkg::*;

    logic      r_valid;
    t_out_beat r_data;
    logic      r_a_done;

    logic      load;
    logic      use_a;
    logic      last;
    t_token    tok;
    t_out_beat beat;

    assign load  = !r_valid || i_ready;
    assign use_a = i_head.a_valid && !r_a_done;
    assign last  = !use_a || !i_head.b_valid;
    assign tok   = use_a ? i_head.tok_a : i_head.tok_b;
    assign o_pop = load && i_head_valid && last;

    always_comb begin
        beat.token_kind      = tok.kind;
        beat.token_start     = tok.start;
        beat.token_length    = tok.length;
        beat.bool_value      = tok.bool_value;
        beat.last_of_run     = last;
        beat.offset_overflow = i_head.overflow;
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_data <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_a_done <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_a_done <= !last;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTH
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_of_run) |=> o_valid)
        else $error("second token of a byte did not follow");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.token_kind == KIND_LBRACE || o_data.token_kind == KIND_RBRACE ||
                     o_data.token_kind == KIND_COLON || o_data.token_kind == KIND_COMMA ||
                     o_data.token_kind == KIND_LBRACK || o_data.token_kind == KIND_RBRACK))
        |-> (o_data.token_length == 16'd0))
        else $error("punctuation token with nonzero length");
`endif

endmodule

// ===== design/json_token_lexer.sv =====
// Path: an accepted byte is written into the token queue, and its first token
//   is then loaded from the queue head into the output register; a second
//   token of the same byte follows once the first has been taken.
// Throughput: one text byte per cycle while the four-entry token queue has
//   room; one token beat per cycle while i_ready is high, one beat per token.
// Reset: synchronous, active low; clears lexer state, queue and output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_lexer - streaming JSON tokenizer
// Takes JSON text one byte per beat, or an end marker, and emits one result
// beat per token with its kind, start offset and length.
// ----------------------------------------------------------------------------
module json_token_lexer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jtl_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output jtl_pkg::t_out_beat o_data
);
    import jtl_pkg::*;

    // The front end owns all lexer state. It classifies each byte against the
    // current mode (idle, string, number, word) and builds a queue entry that
    // holds the token closed by this byte and the punctuation token that the
    // byte itself produces, either of which may be absent.
    logic   push;
    logic   room;
    t_entry push_entry;

    // The queue lets the front end keep taking bytes while the output side is
    // stalled, and lets the output side drain while input is idle.
    logic   pop;
    logic   head_valid;
    t_entry head;

    jtl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_room  (room),
        .o_push  (push),
        .o_entry (push_entry)
    );

    jtl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_room       (room),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // The back end splits each entry into one result beat per token, marks
    // the final one with last_of_run, and holds it in an output register.
    jtl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule
